// ===== rtl/gpad_pkg.sv =====
`default_nettype none

package gpad_pkg;

    localparam int NUM_AXES   = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;
    localparam int MASK_W     = 16;

    // one axis worth of division work, prepared by the front end
    typedef struct packed {
        logic       neg;    // sample below center
        logic       zero;   // result is 0, no division needed
        logic [5:0] num;    // |raw - center|
        logic [6:0] den;    // |bound - center|
    } gpad_axis_job_t;

    typedef struct packed {
        gpad_axis_job_t [NUM_AXES-1:0] axis;
        logic [4:0]                    right_y_raw;
        logic [4:0]                    right_x_raw;
        logic [5:0]                    left_y_raw;
        logic [5:0]                    left_x_raw;
        logic [MASK_W-1:0]             buttons;
    } gpad_entry_t;

endpackage

`default_nettype wire

// ===== rtl/gpad_front.sv =====
`default_nettype none

module gpad_front #(
    parameter int CAL_MARGIN = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gpad_pkg::MASK_W-1:0]    cfg_wr_data,
    input  wire logic                           in_valid,
    input  wire logic [gpad_pkg::IN_DATA_W-1:0] in_data,
    output logic                                in_ready,
    input  wire logic                           q_full,
    output logic                                push,
    output gpad_pkg::gpad_entry_t               push_entry
);
    import gpad_pkg::*;

    localparam logic [8:0] MARGIN = 9'(CAL_MARGIN);

    logic [MASK_W-1:0]  mask_reg;
    logic               cal_reg  [NUM_AXES];
    logic signed [7:0]  low_reg  [NUM_AXES];
    logic [5:0]         mid_reg  [NUM_AXES];
    logic [6:0]         high_reg [NUM_AXES];

    logic               clear;
    logic [7:0]         b0, b1, b2;
    logic [15:0]        word;
    logic [5:0]         raw   [NUM_AXES];
    logic               cal   [NUM_AXES];
    logic signed [8:0]  raw_s [NUM_AXES];
    logic signed [8:0]  low0  [NUM_AXES];
    logic signed [8:0]  low1  [NUM_AXES];
    logic [8:0]         high0 [NUM_AXES];
    logic [8:0]         high1 [NUM_AXES];
    logic [5:0]         mid   [NUM_AXES];
    logic signed [8:0]  dlow  [NUM_AXES];
    logic [8:0]         dhigh [NUM_AXES];

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign clear = in_data[0];
    assign b0    = in_data[8:1];
    assign b1    = in_data[16:9];
    assign b2    = in_data[24:17];
    assign word  = in_data[40:25];

    always_comb
    begin
        raw[0] = b0[5:0];
        raw[1] = b1[5:0];
        raw[2] = {1'b0, b0[7:6], b1[7:6], b2[7]};
        raw[3] = {1'b0, b2[4:0]};

        push_entry.buttons     = ~word & mask_reg;
        push_entry.left_x_raw  = raw[0];
        push_entry.left_y_raw  = raw[1];
        push_entry.right_x_raw = raw[2][4:0];
        push_entry.right_y_raw = raw[3][4:0];

        for (int k = 0; k < NUM_AXES; k++)
        begin
            cal[k]   = cal_reg[k] && !clear;
            raw_s[k] = $signed({3'b000, raw[k]});
            // first sample sets center and bounds at +/- margin
            low0[k]  = cal[k] ? $signed({low_reg[k][7], low_reg[k]})
                              : raw_s[k] - $signed(MARGIN);
            high0[k] = cal[k] ? {2'b00, high_reg[k]} : {3'b000, raw[k]} + MARGIN;
            mid[k]   = cal[k] ? mid_reg[k] : raw[k];
            low1[k]  = (raw_s[k] < low0[k]) ? raw_s[k] : low0[k];
            high1[k] = ({3'b000, raw[k]} > high0[k]) ? {3'b000, raw[k]} : high0[k];
            dlow[k]  = $signed({3'b000, mid[k]}) - low1[k];
            dhigh[k] = high1[k] - {3'b000, mid[k]};

            push_entry.axis[k].neg  = 1'b0;
            push_entry.axis[k].zero = 1'b1;
            push_entry.axis[k].num  = '0;
            push_entry.axis[k].den  = '0;
            if (raw[k] < mid[k])
            begin
                push_entry.axis[k].neg  = 1'b1;
                push_entry.axis[k].zero = (dlow[k] <= 9'sd0);
                push_entry.axis[k].num  = mid[k] - raw[k];
                push_entry.axis[k].den  = dlow[k][6:0];
            end
            else if (raw[k] > mid[k])
            begin
                push_entry.axis[k].zero = (high1[k] <= {3'b000, mid[k]});
                push_entry.axis[k].num  = raw[k] - mid[k];
                push_entry.axis[k].den  = dhigh[k][6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '1;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                cal_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (push)
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    cal_reg[k] <= 1'b1;
                end
            end
        end
    end

    // bounds hold no reset value; they are read only once calibrated
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                low_reg[k]  <= low1[k][7:0];
                mid_reg[k]  <= mid[k];
                high_reg[k] <= high1[k][6:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gpad_queue.sv =====
`default_nettype none

module gpad_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire gpad_pkg::gpad_entry_t push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output gpad_pkg::gpad_entry_t      head_entry
);
    import gpad_pkg::*;

    gpad_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gpad_back.sv =====
`default_nettype none

module gpad_back #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            head_valid,
    input  wire gpad_pkg::gpad_entry_t           head_entry,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [gpad_pkg::OUT_DATA_W-1:0]      out_data
);
    import gpad_pkg::*;

    localparam int QW  = FRAC_BITS + 1;
    localparam int QXW = (QW > 17) ? QW : 17;
    localparam int LW  = $clog2(FRAC_BITS + 2);
    localparam logic [LW-1:0] STEPS = LW'(FRAC_BITS + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t                state_reg, state_next;
    gpad_entry_t           item_reg, item_next;
    logic [1:0]            axis_reg, axis_next;
    logic                  first_reg, first_next;
    logic [6:0]            rem_reg, rem_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [LW-1:0]         left_reg, left_next;
    logic [15:0]           val_reg [NUM_AXES];
    logic [15:0]           val_next [NUM_AXES];
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    gpad_axis_job_t job;
    logic [7:0]     den8, t_a, t_b, r_a8, r_b8;
    logic           bit_a, bit_b, two;
    logic [QW-1:0]  q_step;

    function automatic logic [15:0] sat_val(input logic [QW-1:0] q, input logic neg);
        logic [QXW-1:0] qx;
        qx = QXW'(q);
        if (!neg)
        begin
            return (qx > QXW'(32767)) ? 16'h7FFF : qx[15:0];
        end
        return (qx > QXW'(32768)) ? 16'h8000 : 16'd0 - qx[15:0];
    endfunction

    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // restoring division, two quotient bits a cycle (one when a single bit is left); the first step
    // compares the bare numerator since it never exceeds the divisor
    always_comb
    begin
        job   = item_reg.axis[axis_reg];
        den8  = {1'b0, job.den};
        t_a   = first_reg ? {2'b00, job.num} : {rem_reg, 1'b0};
        bit_a = (t_a >= den8);
        r_a8  = bit_a ? t_a - den8 : t_a;
        t_b   = {r_a8[6:0], 1'b0};
        bit_b = (t_b >= den8);
        r_b8  = bit_b ? t_b - den8 : t_b;
        two   = (left_reg >= LW'(2));
        q_step = two ? {q_reg[QW-3:0], bit_a, bit_b} : {q_reg[QW-2:0], bit_a};
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        axis_next      = axis_reg;
        first_next     = first_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        left_next      = left_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    item_next  = head_entry;
                    axis_next  = 2'd0;
                    first_next = 1'b1;
                    left_next  = STEPS;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (job.zero || left_reg <= LW'(2))
                begin
                    val_next[axis_reg] = job.zero ? 16'd0 : sat_val(q_step, job.neg);
                    first_next = 1'b1;
                    left_next  = STEPS;
                    if (axis_reg == 2'd3)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    q_next     = q_step;
                    rem_next   = two ? r_b8[6:0] : r_a8[6:0];
                    left_next  = left_reg - (two ? LW'(2) : LW'(1));
                    first_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, val_reg[3], val_reg[2], val_reg[1], val_reg[0],
                                      item_reg.right_y_raw, item_reg.right_x_raw,
                                      item_reg.left_y_raw, item_reg.left_x_raw,
                                      item_reg.buttons};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            axis_reg      <= 2'd0;
            first_reg     <= 1'b1;
            rem_reg       <= '0;
            q_reg         <= '0;
            left_reg      <= STEPS;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                val_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            axis_reg      <= axis_next;
            first_reg     <= first_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            left_reg      <= left_next;
            val_reg       <= val_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gamepad_report_autocal_decoder.sv =====
`default_nettype none

// Requests pass decode and calibration into the queue, then the one shared
// two-bit-per-cycle divider that works the four axes in turn; an axis sitting
// at its center skips the division. New requests are taken while the divider
// is busy, until the queue is full.
// A two-entry queue sits between decode/calibration and the divider.
// Reset clears calibration, the queue and the output; button_mask resets to all ones.
module gamepad_report_autocal_decoder #(
    parameter int FRAC_BITS  = 14,
    parameter int CAL_MARGIN = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gpad_pkg::MASK_W-1:0]     cfg_wr_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // clear_calibration, report_byte0, report_byte1, report_byte2, button_word
    input  wire logic [gpad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // buttons, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
    // left_x_value, left_y_value, right_x_value, right_y_value
    output logic [gpad_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import gpad_pkg::*;

    logic        q_full;
    logic        push;
    logic        pop;
    logic        head_valid;
    gpad_entry_t push_entry;
    gpad_entry_t head_entry;

    gpad_front #(
        .CAL_MARGIN (CAL_MARGIN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .in_ready    (s_axis_tready),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    gpad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    gpad_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire
